// ===== hw/rtl/fsmc_pkg.sv =====
// Shared types, constants and codes of the Forth stack machine core.
`default_nettype none
package fsmc_pkg;

    localparam int CELL_W      = 32;
    localparam int ADDR_W      = 12;
    localparam int MEM_WORDS   = 4096;
    localparam int STK_DEPTH   = 64;
    localparam int STK_ENTRIES = STK_DEPTH + 1;
    localparam int SP_W        = $clog2(STK_ENTRIES);
    localparam int ACT_W       = 2;
    localparam int ST_W        = 2;
    localparam int OP_W        = 6;
    localparam int BYTE_SH     = $clog2(CELL_W / 8);

    // Item actions.
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PC    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_EXEC  = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_RUN    = 2'd0;
    localparam logic [ST_W-1:0] ST_HALT   = 2'd1;
    localparam logic [ST_W-1:0] ST_UNSUP  = 2'd2;
    localparam logic [ST_W-1:0] ST_LOOPOV = 2'd3;

    // Primitive opcodes.
    localparam logic [OP_W-1:0] OP_EXIT   = 6'd0;
    localparam logic [OP_W-1:0] OP_LIT    = 6'd1;
    localparam logic [OP_W-1:0] OP_JMP    = 6'd2;
    localparam logic [OP_W-1:0] OP_JMPZ   = 6'd3;
    localparam logic [OP_W-1:0] OP_JMPNZ  = 6'd4;
    localparam logic [OP_W-1:0] OP_NJMPZ  = 6'd5;
    localparam logic [OP_W-1:0] OP_NJMPNZ = 6'd6;
    localparam logic [OP_W-1:0] OP_DUP    = 6'd7;
    localparam logic [OP_W-1:0] OP_DROP   = 6'd8;
    localparam logic [OP_W-1:0] OP_SWAP   = 6'd9;
    localparam logic [OP_W-1:0] OP_OVER   = 6'd10;
    localparam logic [OP_W-1:0] OP_STORE  = 6'd11;
    localparam logic [OP_W-1:0] OP_FETCH  = 6'd12;
    localparam logic [OP_W-1:0] OP_CSTORE = 6'd13;
    localparam logic [OP_W-1:0] OP_CFETCH = 6'd14;
    localparam logic [OP_W-1:0] OP_TOR    = 6'd15;
    localparam logic [OP_W-1:0] OP_RAT    = 6'd16;
    localparam logic [OP_W-1:0] OP_RFROM  = 6'd17;
    localparam logic [OP_W-1:0] OP_PLUSL  = 6'd18;
    localparam logic [OP_W-1:0] OP_MINUSL = 6'd19;
    localparam logic [OP_W-1:0] OP_XST    = 6'd20;
    localparam logic [OP_W-1:0] OP_YST    = 6'd21;
    localparam logic [OP_W-1:0] OP_ZST    = 6'd22;
    localparam logic [OP_W-1:0] OP_XAT    = 6'd23;
    localparam logic [OP_W-1:0] OP_YAT    = 6'd24;
    localparam logic [OP_W-1:0] OP_ZAT    = 6'd25;
    localparam logic [OP_W-1:0] OP_MUL    = 6'd26;
    localparam logic [OP_W-1:0] OP_ADD    = 6'd27;
    localparam logic [OP_W-1:0] OP_SUB    = 6'd28;
    localparam logic [OP_W-1:0] OP_DIVMOD = 6'd29;
    localparam logic [OP_W-1:0] OP_INC    = 6'd30;
    localparam logic [OP_W-1:0] OP_DEC    = 6'd31;
    localparam logic [OP_W-1:0] OP_LT     = 6'd32;
    localparam logic [OP_W-1:0] OP_EQ     = 6'd33;
    localparam logic [OP_W-1:0] OP_GT     = 6'd34;
    localparam logic [OP_W-1:0] OP_ZEQ    = 6'd35;
    localparam logic [OP_W-1:0] OP_PLUSST = 6'd36;
    localparam logic [OP_W-1:0] OP_FOR    = 6'd37;
    localparam logic [OP_W-1:0] OP_I      = 6'd38;
    localparam logic [OP_W-1:0] OP_NEXT   = 6'd39;
    localparam logic [OP_W-1:0] OP_AND    = 6'd40;
    localparam logic [OP_W-1:0] OP_OR     = 6'd41;
    localparam logic [OP_W-1:0] OP_XOR    = 6'd42;
    localparam logic [OP_W-1:0] OP_UNS_LO = 6'd43;
    localparam logic [OP_W-1:0] OP_UNS_HI = 6'd56;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hwr;
        logic hrd_issue;
        logic hrd_cap;
        logic e0;
        logic e1;
        logic e2;
        logic e3;
        logic div_start;
        logic plan;
        logic wr0;
        logic wr1;
        logic wr2;
        logic top_issue;
        logic top_cap;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic halted;
        logic is_div;
        logic div_done;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fsmc_ram.sv =====
// Generic single-port-write RAM with a registered read.
`default_nettype none
module fsmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/fsmc_stk.sv =====
// Stack storage: a RAM with per-entry valid bits so that unwritten cells read as zero.
`default_nettype none
module fsmc_stk
    import fsmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SP_W-1:0]   raddr,
    output logic      [CELL_W-1:0] rdata,
    input  wire logic              we,
    input  wire logic [SP_W-1:0]   waddr,
    input  wire logic [CELL_W-1:0] wdata
);

    logic [STK_ENTRIES-1:0] valid_reg;
    logic                   rvalid_reg;
    logic [CELL_W-1:0]      ram_q;

    fsmc_ram #(.WIDTH(CELL_W), .DEPTH(STK_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // Valid bits are set on write and sampled alongside the read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? ram_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/fsmc_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module fsmc_div
    import fsmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CELL_W-1:0] dividend,
    input  wire logic [CELL_W-1:0] divisor,
    output logic      [CELL_W-1:0] quotient,
    output logic      [CELL_W-1:0] remainder,
    output logic                   done
);

    localparam int CNT_W = $clog2(CELL_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [CELL_W-1:0] quo_reg;
    logic [CELL_W-1:0] rem_reg;
    logic [CELL_W-1:0] den_reg;
    logic [CELL_W:0]   shifted;
    logic [CELL_W:0]   diff;

    // One trial subtraction per cycle.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[CELL_W-1]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(CELL_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!diff[CELL_W])
            begin
                rem_reg <= diff[CELL_W-1:0];
                quo_reg <= {quo_reg[CELL_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[CELL_W-1:0];
                quo_reg <= {quo_reg[CELL_W-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/fsmc_ctrl.sv =====
// Controller state machine that sequences host accesses and instruction execution.
`default_nettype none
module fsmc_ctrl
    import fsmc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [ACT_W-1:0] action,
    input  wire sts_t             sts,
    output logic                  busy,
    output cmd_t                  cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_HWR  = 5'd1;
    localparam logic [4:0] S_HRD0 = 5'd2;
    localparam logic [4:0] S_HRD1 = 5'd3;
    localparam logic [4:0] S_E0   = 5'd4;
    localparam logic [4:0] S_E1   = 5'd5;
    localparam logic [4:0] S_E2   = 5'd6;
    localparam logic [4:0] S_E3   = 5'd7;
    localparam logic [4:0] S_DIVS = 5'd8;
    localparam logic [4:0] S_DIVW = 5'd9;
    localparam logic [4:0] S_PLAN = 5'd10;
    localparam logic [4:0] S_WR0  = 5'd11;
    localparam logic [4:0] S_WR1  = 5'd12;
    localparam logic [4:0] S_WR2  = 5'd13;
    localparam logic [4:0] S_TOP0 = 5'd14;
    localparam logic [4:0] S_TOP1 = 5'd15;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_WRITE: state_next = S_HWR;
                        ACT_READ:  state_next = S_HRD0;
                        ACT_PC:    state_next = S_TOP0;
                        default:   state_next = sts.halted ? S_TOP0 : S_E0;
                    endcase
                end
            end
            S_HWR:  state_next = S_TOP0;
            S_HRD0: state_next = S_HRD1;
            S_HRD1: state_next = S_TOP0;
            S_E0:   state_next = S_E1;
            S_E1:   state_next = S_E2;
            S_E2:   state_next = S_E3;
            S_E3:   state_next = sts.is_div ? S_DIVS : S_PLAN;
            S_DIVS: state_next = S_DIVW;
            S_DIVW: state_next = sts.div_done ? S_PLAN : S_DIVW;
            S_PLAN: state_next = S_WR0;
            S_WR0:  state_next = S_WR1;
            S_WR1:  state_next = S_WR2;
            S_WR2:  state_next = S_TOP0;
            S_TOP0: state_next = S_TOP1;
            S_TOP1: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.hwr       = (state_reg == S_HWR);
        cmd.hrd_issue = (state_reg == S_HRD0);
        cmd.hrd_cap   = (state_reg == S_HRD1);
        cmd.e0        = (state_reg == S_E0);
        cmd.e1        = (state_reg == S_E1);
        cmd.e2        = (state_reg == S_E2);
        cmd.e3        = (state_reg == S_E3);
        cmd.div_start = (state_reg == S_DIVS);
        cmd.plan      = (state_reg == S_PLAN);
        cmd.wr0       = (state_reg == S_WR0);
        cmd.wr1       = (state_reg == S_WR1);
        cmd.wr2       = (state_reg == S_WR2);
        cmd.top_issue = (state_reg == S_TOP0);
        cmd.top_cap   = (state_reg == S_TOP1);
    end

    assign busy = (state_reg != S_IDLE);

    // An accepted word always leaves idle.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != S_IDLE))
        else $error("accepted word did not leave idle");

    // The top-of-stack capture always ends the item.
    a_cap_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.top_cap |=> (state_reg == S_IDLE))
        else $error("item did not end after result capture");

    // Divider waits only follow a divider start or a wait.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVW) |-> ($past(state_reg) == S_DIVS || $past(state_reg) == S_DIVW))
        else $error("divider wait entered without start");

endmodule
`default_nettype wire

// ===== hw/rtl/fsmc_dp.sv =====
// Datapath: word memory, four stacks, pointers, divider and instruction execution.
`default_nettype none
module fsmc_dp
    import fsmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [CELL_W-1:0] data,
    output logic                   done,
    output logic      [ADDR_W-1:0] program_counter,
    output logic      [CELL_W-1:0] top_of_stack,
    output logic      [CELL_W-1:0] read_word,
    output logic      [ST_W-1:0]   status
);

    // Architectural registers.
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [SP_W-1:0]   dsp_reg, dsp_next;
    logic [SP_W-1:0]   rsp_reg, rsp_next;
    logic [SP_W-1:0]   lsp_reg, lsp_next;
    logic [SP_W-1:0]   tsp_reg, tsp_next;
    logic              halted_reg, halted_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [CELL_W-1:0] rword_reg;
    logic [CELL_W-1:0] tos_reg;
    logic              done_reg;

    // Host item registers.
    logic [ADDR_W-1:0] haddr_reg;
    logic [CELL_W-1:0] hdata_reg;

    // Operands fetched for one instruction.
    logic [CELL_W-1:0] ir_reg, opnd_reg, t_reg, n_reg, r_reg;
    logic [CELL_W-1:0] l0_reg, l1_reg, l2_reg, f_reg, m_reg;

    // Write plan.
    logic              ds0_en_reg, ds0_en_next, ds1_en_reg, ds1_en_next;
    logic [SP_W-1:0]   ds0_a_reg, ds0_a_next, ds1_a_reg, ds1_a_next;
    logic [CELL_W-1:0] ds0_d_reg, ds0_d_next, ds1_d_reg, ds1_d_next;
    logic              mw_en_reg, mw_en_next;
    logic [ADDR_W-1:0] mw_a_reg, mw_a_next;
    logic [CELL_W-1:0] mw_d_reg, mw_d_next;
    logic              rw_en_reg, rw_en_next;
    logic [SP_W-1:0]   rw_a_reg, rw_a_next;
    logic [CELL_W-1:0] rw_d_reg, rw_d_next;
    logic              fw_en_reg, fw_en_next;
    logic [SP_W-1:0]   fw_a_reg, fw_a_next;
    logic [CELL_W-1:0] fw_d_reg, fw_d_next;
    logic              lw_en_reg [3];
    logic              lw_en_next [3];
    logic [SP_W-1:0]   lw_a_reg [3];
    logic [SP_W-1:0]   lw_a_next [3];
    logic [CELL_W-1:0] lw_d_reg [3];
    logic [CELL_W-1:0] lw_d_next [3];

    // Memory and stack ports.
    logic              mem_we, ds_we, rs_we, ls_we, fs_we;
    logic [ADDR_W-1:0] mem_ra, mem_wa;
    logic [CELL_W-1:0] mem_wd, mem_q;
    logic [SP_W-1:0]   ds_ra, ds_wa, rs_ra, ls_ra, ls_wa, fs_ra;
    logic [CELL_W-1:0] ds_wd, ls_wd, ds_q, rs_q, ls_q, fs_q;

    // Decode and helper values.
    logic [OP_W-1:0]   op;
    logic              is_prim, is_unsup;
    logic [1:0]        fk;
    logic [ADDR_W-1:0] pc1, pc2, dma;
    logic [SP_W-1:0]   dsp_dec, dsp_dec2;
    logic [CELL_W-1:0] tpop, npop2, rpop;
    logic [CELL_W-1:0] an, at, qs, rs_fix, dq, dr;
    logic              div_done;

    assign op       = ir_reg[OP_W-1:0];
    assign is_prim  = (ir_reg[CELL_W-1:OP_W] == '0) && (op <= OP_XOR);
    assign is_unsup = (ir_reg[CELL_W-1:OP_W] == '0) && (op >= OP_UNS_LO) && (op <= OP_UNS_HI);
    assign fk       = (op >= OP_XAT) ? 2'(op - OP_XAT) : 2'(op - OP_XST);
    assign pc1      = pc_reg + 1'b1;
    assign pc2      = pc_reg + 2'd2;
    assign dsp_dec  = (dsp_reg != '0) ? dsp_reg - 1'b1 : '0;
    assign dsp_dec2 = (dsp_reg >= SP_W'(2)) ? dsp_reg - SP_W'(2) : '0;
    assign tpop     = (dsp_reg != '0) ? t_reg : '0;
    assign npop2    = (dsp_reg >= SP_W'(2)) ? n_reg : '0;
    assign rpop     = (rsp_reg != '0) ? r_reg : '0;

    // Data access address for memory primitives.
    always_comb
    begin
        case (op)
            OP_CFETCH: dma = t_reg[ADDR_W+BYTE_SH-1:BYTE_SH];
            OP_STORE:  dma = tpop[ADDR_W-1:0];
            OP_PLUSST: dma = tpop[ADDR_W-1:0];
            OP_CSTORE: dma = tpop[ADDR_W+BYTE_SH-1:BYTE_SH];
            default:   dma = t_reg[ADDR_W-1:0];
        endcase
    end

    // Signed division from magnitudes.
    assign an = n_reg[CELL_W-1] ? -n_reg : n_reg;
    assign at = t_reg[CELL_W-1] ? -t_reg : t_reg;

    fsmc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (an),
        .divisor   (at),
        .quotient  (dq),
        .remainder (dr),
        .done      (div_done)
    );

    assign qs     = (t_reg == '0) ? '0 :
                    ((n_reg[CELL_W-1] ^ t_reg[CELL_W-1]) ? -dq : dq);
    assign rs_fix = (t_reg == '0) ? n_reg : (n_reg[CELL_W-1] ? -dr : dr);

    // Memory and stack port selection per sequencing step.
    always_comb
    begin
        mem_ra = pc_reg;
        if (cmd.e1)
        begin
            mem_ra = pc1;
        end
        else if (cmd.e2)
        begin
            mem_ra = dma;
        end
        else if (cmd.hrd_issue)
        begin
            mem_ra = haddr_reg;
        end
        mem_we = cmd.hwr || (cmd.wr0 && mw_en_reg);
        mem_wa = cmd.hwr ? haddr_reg : mw_a_reg;
        mem_wd = cmd.hwr ? hdata_reg : mw_d_reg;

        ds_ra = cmd.e1 ? dsp_dec : dsp_reg;
        ds_we = (cmd.wr0 && ds0_en_reg) || (cmd.wr1 && ds1_en_reg);
        ds_wa = cmd.wr1 ? ds1_a_reg : ds0_a_reg;
        ds_wd = cmd.wr1 ? ds1_d_reg : ds0_d_reg;

        rs_ra = rsp_reg;
        rs_we = cmd.wr0 && rw_en_reg;

        ls_ra = lsp_reg;
        if (cmd.e1)
        begin
            ls_ra = lsp_reg - 1'b1;
        end
        else if (cmd.e2)
        begin
            ls_ra = lsp_reg - SP_W'(2);
        end
        ls_we = 1'b0;
        ls_wa = lw_a_reg[0];
        ls_wd = lw_d_reg[0];
        if (cmd.wr0)
        begin
            ls_we = lw_en_reg[0];
        end
        else if (cmd.wr1)
        begin
            ls_we = lw_en_reg[1];
            ls_wa = lw_a_reg[1];
            ls_wd = lw_d_reg[1];
        end
        else if (cmd.wr2)
        begin
            ls_we = lw_en_reg[2];
            ls_wa = lw_a_reg[2];
            ls_wd = lw_d_reg[2];
        end

        fs_ra = tsp_reg + SP_W'(fk);
        fs_we = cmd.wr0 && fw_en_reg;
    end

    fsmc_ram #(.WIDTH(CELL_W), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .raddr (mem_ra),
        .rdata (mem_q)
    );

    fsmc_stk u_ds (
        .clk (clk), .rst_n (rst_n), .raddr (ds_ra), .rdata (ds_q),
        .we (ds_we), .waddr (ds_wa), .wdata (ds_wd)
    );

    fsmc_stk u_rs (
        .clk (clk), .rst_n (rst_n), .raddr (rs_ra), .rdata (rs_q),
        .we (rs_we), .waddr (rw_a_reg), .wdata (rw_d_reg)
    );

    fsmc_stk u_ls (
        .clk (clk), .rst_n (rst_n), .raddr (ls_ra), .rdata (ls_q),
        .we (ls_we), .waddr (ls_wa), .wdata (ls_wd)
    );

    fsmc_stk u_fs (
        .clk (clk), .rst_n (rst_n), .raddr (fs_ra), .rdata (fs_q),
        .we (fs_we), .waddr (fw_a_reg), .wdata (fw_d_reg)
    );

    // Instruction execution: new pointers, pc, status and the write plan.
    always_comb
    begin
        logic              push_req;
        logic [CELL_W-1:0] push_v;
        logic              take;
        logic [CELL_W-1:0] res;
        logic [CELL_W-1:0] w;
        logic [4:0]        sh;

        push_req = 1'b0;
        push_v   = '0;
        take     = 1'b0;
        res      = '0;
        w        = l0_reg + 1'b1;
        sh       = {t_reg[1:0], 3'b000};

        pc_next     = pc1;
        dsp_next    = dsp_reg;
        rsp_next    = rsp_reg;
        lsp_next    = lsp_reg;
        tsp_next    = tsp_reg;
        halted_next = halted_reg;
        status_next = ST_RUN;
        ds0_en_next = 1'b0;
        ds0_a_next  = dsp_reg;
        ds0_d_next  = '0;
        ds1_en_next = 1'b0;
        ds1_a_next  = dsp_dec;
        ds1_d_next  = '0;
        mw_en_next  = 1'b0;
        mw_a_next   = dma;
        mw_d_next   = '0;
        rw_en_next  = 1'b0;
        rw_a_next   = rsp_reg + 1'b1;
        rw_d_next   = '0;
        fw_en_next  = 1'b0;
        fw_a_next   = tsp_reg + SP_W'(fk);
        fw_d_next   = tpop;
        for (int k = 0; k < 3; k++)
        begin
            lw_en_next[k] = 1'b0;
            lw_a_next[k]  = lsp_reg;
            lw_d_next[k]  = '0;
        end

        if (is_prim)
        begin
            case (op)
                OP_EXIT:
                begin
                    rsp_next = (rsp_reg != '0) ? rsp_reg - 1'b1 : '0;
                    pc_next  = rpop[ADDR_W-1:0];
                    if (rpop[ADDR_W-1:0] == '0)
                    begin
                        halted_next = 1'b1;
                        status_next = ST_HALT;
                    end
                end
                OP_LIT:
                begin
                    push_req = 1'b1;
                    push_v   = opnd_reg;
                    pc_next  = pc2;
                end
                OP_JMP: pc_next = opnd_reg[ADDR_W-1:0];
                OP_JMPZ, OP_JMPNZ, OP_NJMPZ, OP_NJMPNZ:
                begin
                    res = (op <= OP_JMPNZ) ? tpop : t_reg;
                    if (op <= OP_JMPNZ)
                    begin
                        dsp_next = dsp_dec;
                    end
                    if ((res == '0) == (op == OP_JMPZ || op == OP_NJMPZ))
                    begin
                        pc_next = opnd_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        pc_next = pc2;
                    end
                end
                OP_DUP:
                begin
                    push_req = 1'b1;
                    push_v   = t_reg;
                end
                OP_DROP: dsp_next = dsp_dec;
                OP_SWAP:
                begin
                    ds0_en_next = 1'b1;
                    ds0_d_next  = n_reg;
                    ds1_en_next = 1'b1;
                    ds1_d_next  = t_reg;
                end
                OP_OVER:
                begin
                    push_req = 1'b1;
                    push_v   = n_reg;
                end
                OP_STORE:
                begin
                    dsp_next   = dsp_dec2;
                    mw_en_next = 1'b1;
                    mw_d_next  = npop2;
                end
                OP_FETCH:
                begin
                    ds0_en_next = 1'b1;
                    ds0_d_next  = m_reg;
                end
                OP_CSTORE:
                begin
                    dsp_next   = dsp_dec2;
                    mw_en_next = 1'b1;
                    sh         = {tpop[1:0], 3'b000};
                    mw_d_next  = (m_reg & ~(CELL_W'(8'hFF) << sh))
                               | (CELL_W'(npop2[7:0]) << sh);
                end
                OP_CFETCH:
                begin
                    ds0_en_next = 1'b1;
                    ds0_d_next  = CELL_W'(8'(m_reg >> sh));
                end
                OP_TOR:
                begin
                    dsp_next = dsp_dec;
                    if (rsp_reg < SP_W'(STK_DEPTH))
                    begin
                        rsp_next   = rsp_reg + 1'b1;
                        rw_en_next = 1'b1;
                        rw_d_next  = tpop;
                    end
                end
                OP_RAT:
                begin
                    push_req = 1'b1;
                    push_v   = r_reg;
                end
                OP_RFROM:
                begin
                    rsp_next = (rsp_reg != '0) ? rsp_reg - 1'b1 : '0;
                    push_req = 1'b1;
                    push_v   = rpop;
                end
                OP_PLUSL:
                begin
                    if (({1'b0, tsp_reg} + (SP_W+1)'(5)) <= (SP_W+1)'(STK_DEPTH))
                    begin
                        tsp_next = tsp_reg + SP_W'(3);
                    end
                end
                OP_MINUSL:
                begin
                    if (tsp_reg > SP_W'(2))
                    begin
                        tsp_next = tsp_reg - SP_W'(3);
                    end
                end
                OP_XST, OP_YST, OP_ZST:
                begin
                    dsp_next   = dsp_dec;
                    fw_en_next = 1'b1;
                end
                OP_XAT, OP_YAT, OP_ZAT:
                begin
                    push_req = 1'b1;
                    push_v   = f_reg;
                end
                OP_MUL, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
                OP_LT, OP_EQ, OP_GT:
                begin
                    take = 1'b1;
                    case (op)
                        OP_MUL:  res = n_reg * tpop;
                        OP_ADD:  res = n_reg + tpop;
                        OP_SUB:  res = n_reg - tpop;
                        OP_AND:  res = n_reg & tpop;
                        OP_OR:   res = n_reg | tpop;
                        OP_XOR:  res = n_reg ^ tpop;
                        OP_LT:   res = CELL_W'($signed(n_reg) < $signed(tpop));
                        OP_EQ:   res = CELL_W'(n_reg == tpop);
                        default: res = CELL_W'($signed(tpop) < $signed(n_reg));
                    endcase
                    dsp_next    = dsp_dec;
                    ds0_en_next = 1'b1;
                    ds0_a_next  = dsp_dec;
                    ds0_d_next  = res;
                end
                OP_DIVMOD:
                begin
                    ds0_en_next = 1'b1;
                    ds0_d_next  = qs;
                    ds1_en_next = 1'b1;
                    ds1_d_next  = rs_fix;
                end
                OP_INC:
                begin
                    ds0_en_next = 1'b1;
                    ds0_d_next  = t_reg + 1'b1;
                end
                OP_DEC:
                begin
                    ds0_en_next = 1'b1;
                    ds0_d_next  = t_reg - 1'b1;
                end
                OP_ZEQ:
                begin
                    ds0_en_next = 1'b1;
                    ds0_d_next  = CELL_W'(t_reg == '0);
                end
                OP_PLUSST:
                begin
                    dsp_next   = dsp_dec2;
                    mw_en_next = 1'b1;
                    mw_d_next  = m_reg + npop2;
                end
                OP_FOR:
                begin
                    dsp_next = dsp_dec;
                    if (({1'b0, lsp_reg} + (SP_W+1)'(3)) > (SP_W+1)'(STK_DEPTH))
                    begin
                        status_next = ST_LOOPOV;
                    end
                    else
                    begin
                        lsp_next      = lsp_reg + SP_W'(3);
                        lw_en_next[0] = 1'b1;
                        lw_a_next[0]  = lsp_reg + SP_W'(3);
                        lw_d_next[0]  = '0;
                        lw_en_next[1] = 1'b1;
                        lw_a_next[1]  = lsp_reg + SP_W'(2);
                        lw_d_next[1]  = tpop;
                        lw_en_next[2] = 1'b1;
                        lw_a_next[2]  = lsp_reg + SP_W'(1);
                        lw_d_next[2]  = CELL_W'(pc1);
                    end
                end
                OP_I:
                begin
                    push_req = 1'b1;
                    push_v   = l0_reg;
                end
                OP_NEXT:
                begin
                    if (lsp_reg >= SP_W'(3))
                    begin
                        lw_en_next[0] = 1'b1;
                        lw_d_next[0]  = w;
                        if ($signed(w) < $signed(l1_reg))
                        begin
                            pc_next = l2_reg[ADDR_W-1:0];
                        end
                        else
                        begin
                            lsp_next = lsp_reg - SP_W'(3);
                        end
                    end
                end
                default:
                begin
                    status_next = ST_RUN;
                end
            endcase
        end
        else if (is_unsup)
        begin
            status_next = ST_UNSUP;
        end
        else if (ir_reg[CELL_W-2])
        begin
            // Short literal.
            push_req = 1'b1;
            push_v   = {2'b00, ir_reg[CELL_W-3:0]};
        end
        else
        begin
            // Call; the return address is skipped when the next word is exit.
            pc_next = ir_reg[ADDR_W-1:0];
            if (opnd_reg != '0 && rsp_reg < SP_W'(STK_DEPTH))
            begin
                rsp_next   = rsp_reg + 1'b1;
                rw_en_next = 1'b1;
                rw_d_next  = CELL_W'(pc1);
            end
        end

        // Data stack push, ignored when full.
        if (push_req && dsp_reg < SP_W'(STK_DEPTH))
        begin
            dsp_next    = dsp_reg + 1'b1;
            ds0_en_next = 1'b1;
            ds0_a_next  = dsp_reg + 1'b1;
            ds0_d_next  = push_v;
        end
        if (take)
        begin
            ds0_a_next = dsp_dec;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            dsp_reg    <= '0;
            rsp_reg    <= '0;
            lsp_reg    <= '0;
            tsp_reg    <= '0;
            halted_reg <= 1'b0;
            status_reg <= ST_RUN;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.top_cap;
            if (cmd.load)
            begin
                status_reg <= halted_reg ? ST_HALT : ST_RUN;
                if (action == ACT_PC)
                begin
                    pc_reg     <= address;
                    halted_reg <= 1'b0;
                    status_reg <= ST_RUN;
                end
            end
            else if (cmd.plan)
            begin
                pc_reg     <= pc_next;
                dsp_reg    <= dsp_next;
                rsp_reg    <= rsp_next;
                lsp_reg    <= lsp_next;
                tsp_reg    <= tsp_next;
                halted_reg <= halted_next;
                status_reg <= status_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            haddr_reg <= address;
            hdata_reg <= data;
            rword_reg <= '0;
        end
        if (cmd.hrd_cap)
        begin
            rword_reg <= mem_q;
        end
        if (cmd.e1)
        begin
            ir_reg <= mem_q;
            t_reg  <= ds_q;
            r_reg  <= rs_q;
            l0_reg <= ls_q;
        end
        if (cmd.e2)
        begin
            opnd_reg <= mem_q;
            n_reg    <= ds_q;
            l1_reg   <= ls_q;
        end
        if (cmd.e3)
        begin
            l2_reg <= ls_q;
            f_reg  <= fs_q;
            m_reg  <= mem_q;
        end
        if (cmd.plan)
        begin
            ds0_en_reg <= ds0_en_next;
            ds0_a_reg  <= ds0_a_next;
            ds0_d_reg  <= ds0_d_next;
            ds1_en_reg <= ds1_en_next;
            ds1_a_reg  <= ds1_a_next;
            ds1_d_reg  <= ds1_d_next;
            mw_en_reg  <= mw_en_next;
            mw_a_reg   <= mw_a_next;
            mw_d_reg   <= mw_d_next;
            rw_en_reg  <= rw_en_next;
            rw_a_reg   <= rw_a_next;
            rw_d_reg   <= rw_d_next;
            fw_en_reg  <= fw_en_next;
            fw_a_reg   <= fw_a_next;
            fw_d_reg   <= fw_d_next;
            for (int k = 0; k < 3; k++)
            begin
                lw_en_reg[k] <= lw_en_next[k];
                lw_a_reg[k]  <= lw_a_next[k];
                lw_d_reg[k]  <= lw_d_next[k];
            end
        end
        if (cmd.top_cap)
        begin
            tos_reg <= ds_q;
        end
    end

    assign sts.halted   = halted_reg;
    assign sts.is_div   = is_prim && (op == OP_DIVMOD);
    assign sts.div_done = div_done;

    assign done            = done_reg;
    assign program_counter = pc_reg;
    assign top_of_stack    = tos_reg;
    assign read_word       = rword_reg;
    assign status          = status_reg;

    // Stack pointers stay within their stacks.
    a_dsp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dsp_reg <= SP_W'(STK_DEPTH)) && (rsp_reg <= SP_W'(STK_DEPTH)))
        else $error("data or return stack pointer out of range");

    // A frame never reaches past the top of the frame stack, and the loop stack pointer stays in range.
    a_tsp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tsp_reg + SP_W'(2) <= SP_W'(STK_DEPTH)) && (lsp_reg <= SP_W'(STK_DEPTH)))
        else $error("frame or loop stack pointer out of range");

    // A halted machine only leaves halt through a start pc load.
    a_halt_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(halted_reg) && !halted_reg) |-> $past(cmd.load && action == ACT_PC))
        else $error("halt cleared without a start pc load");

endmodule
`default_nettype wire

// ===== hw/rtl/forth_stack_machine_core_unit.sv =====
// Top level of the Forth stack machine core.
//
// Command channel: a word (action, address, data) is taken at a rising edge where
// start is high and busy is low. Actions write a memory word, read a memory word,
// set the start program counter, or execute one instruction.
// Result channel: done is high for exactly one cycle with program_counter,
// top_of_stack, read_word and status; the receiver cannot stall it.
// An executed /mod also waits for the one-bit-per-cycle divider. Each execution
// steps through fetch, operand fetch, data read, plan, three write steps and a
// top-of-stack read, since each memory and stack has one read and one write
// port. busy is high from acceptance to done, so the next word can be taken in
// the cycle that done is shown.
// Reset clears the pc, the stack pointers, the halt flag and the stack valid bits;
// word memory is not cleared and must be written before it is read.
`default_nettype none
module forth_stack_machine_core_unit
    import fsmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [CELL_W-1:0] data,
    output logic                   done,
    output logic      [ADDR_W-1:0] program_counter,
    output logic      [CELL_W-1:0] top_of_stack,
    output logic      [CELL_W-1:0] read_word,
    output logic      [ST_W-1:0]   status
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    fsmc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Storage and execution.
    fsmc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (action),
        .address         (address),
        .data            (data),
        .done            (done),
        .program_counter (program_counter),
        .top_of_stack    (top_of_stack),
        .read_word       (read_word),
        .status          (status)
    );

endmodule
`default_nettype wire

// ===== bench/forth_stack_machine_core_unit_tb.sv =====
// Self-checking testbench for the Forth stack machine core, with its own instruction predictor.
`default_nettype none
module forth_stack_machine_core_unit_tb;
    import fsmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result word.
    typedef struct {
        logic [ADDR_W-1:0] pc;
        logic [CELL_W-1:0] tos;
        logic [CELL_W-1:0] rd;
        logic [ST_W-1:0]   st;
    } outcome_t;

    // One row of the directed table; typed rows carry their own answer.
    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [ADDR_W-1:0] adr;
        logic [CELL_W-1:0] dat;
        int                reps;
        bit                typed;
        logic [ADDR_W-1:0] e_pc;
        logic [CELL_W-1:0] e_tos;
        logic [CELL_W-1:0] e_rd;
        logic [ST_W-1:0]   e_st;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [ACT_W-1:0]  action = ACT_WRITE;
    logic [ADDR_W-1:0] address = '0;
    logic [CELL_W-1:0] data = '0;
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] program_counter;
    logic [CELL_W-1:0] top_of_stack;
    logic [CELL_W-1:0] read_word;
    logic [ST_W-1:0]   status;

    outcome_t pending_results[$];
    int       error_count = 0;
    int       gap_pct = 15;

    // Machine state as the predictor sees it.
    logic [CELL_W-1:0] mem_img[MEM_WORDS];
    logic [CELL_W-1:0] dstk[STK_ENTRIES];
    logic [CELL_W-1:0] rstk[STK_ENTRIES];
    logic [CELL_W-1:0] lstk[STK_ENTRIES];
    logic [CELL_W-1:0] fstk[STK_ENTRIES];
    int unsigned       dsp = 0, rsp = 0, lsp_m = 0, fsp = 0;
    logic [ADDR_W-1:0] pc_m = '0;
    bit                halted_m = 1'b0;

    forth_stack_machine_core_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .address(address), .data(data),
        .done(done), .program_counter(program_counter), .top_of_stack(top_of_stack),
        .read_word(read_word), .status(status)
    );

    always #5 clk = ~clk;

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    function automatic void push_data(logic [CELL_W-1:0] v);
        if (dsp < STK_DEPTH)
        begin
            dsp++;
            dstk[dsp] = v;
        end
    endfunction

    function automatic logic [CELL_W-1:0] pop_data();
        if (dsp > 0)
        begin
            dsp--;
            return dstk[dsp + 1];
        end
        return '0;
    endfunction

    function automatic void push_ret(logic [CELL_W-1:0] v);
        if (rsp < STK_DEPTH)
        begin
            rsp++;
            rstk[rsp] = v;
        end
    endfunction

    function automatic logic [CELL_W-1:0] pop_ret();
        if (rsp > 0)
        begin
            rsp--;
            return rstk[rsp + 1];
        end
        return '0;
    endfunction

    function automatic int unsigned second_cell();
        return dsp > 0 ? dsp - 1 : 0;
    endfunction

    // Execute the instruction at the program counter and return its status.
    function automatic logic [ST_W-1:0] run_instruction();
        logic [ADDR_W-1:0] pc;
        logic [CELL_W-1:0] ir, t, n, w, an, at, q, r;
        int unsigned       top, tsp, lsp, sec;
        logic [ST_W-1:0]   st;
        pc = pc_m;
        ir = mem_img[pc];
        tsp = fsp;
        lsp = lsp_m;
        top = dsp;
        st = ST_RUN;
        pc = pc + 1'b1;
        case (ir)
            OP_EXIT:
            begin
                pc = ADDR_W'(pop_ret());
                if (pc == 0)
                begin
                    halted_m = 1'b1;
                    st = ST_HALT;
                end
            end
            OP_LIT:
            begin
                push_data(mem_img[pc]);
                pc = pc + 1'b1;
            end
            OP_JMP: pc = mem_img[pc][ADDR_W-1:0];
            OP_JMPZ, OP_JMPNZ, OP_NJMPZ, OP_NJMPNZ:
            begin
                t = (ir <= OP_JMPNZ) ? pop_data() : dstk[top];
                if ((t == 0) == (ir == OP_JMPZ || ir == OP_NJMPZ))
                    pc = mem_img[pc][ADDR_W-1:0];
                else
                    pc = pc + 1'b1;
            end
            OP_DUP:  push_data(dstk[top]);
            OP_DROP: void'(pop_data());
            OP_SWAP:
            begin
                sec = second_cell();
                t = dstk[top];
                dstk[top] = dstk[sec];
                dstk[sec] = t;
            end
            OP_OVER: push_data(dstk[second_cell()]);
            OP_STORE:
            begin
                t = pop_data();
                n = pop_data();
                mem_img[t[ADDR_W-1:0]] = n;
            end
            OP_FETCH: dstk[top] = mem_img[dstk[top][ADDR_W-1:0]];
            OP_CSTORE:
            begin
                t = pop_data();
                n = pop_data();
                mem_img[t[ADDR_W+1:2]][t[1:0]*8 +: 8] = n[7:0];
            end
            OP_CFETCH:
            begin
                t = dstk[top];
                dstk[top] = {24'h0, mem_img[t[ADDR_W+1:2]][t[1:0]*8 +: 8]};
            end
            OP_TOR:   push_ret(pop_data());
            OP_RAT:   push_data(rstk[rsp]);
            OP_RFROM: push_data(pop_ret());
            OP_PLUSL:
            begin
                if (tsp + 5 <= STK_DEPTH)
                    fsp = tsp + 3;
            end
            OP_MINUSL:
            begin
                if (tsp > 2)
                    fsp = tsp - 3;
            end
            OP_XST, OP_YST, OP_ZST: fstk[tsp + int'(ir - OP_XST)] = pop_data();
            OP_XAT, OP_YAT, OP_ZAT: push_data(fstk[tsp + int'(ir - OP_XAT)]);
            OP_MUL, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:
            begin
                t = pop_data();
                top = dsp;
                n = dstk[top];
                case (ir)
                    OP_MUL:  n = n * t;
                    OP_ADD:  n = n + t;
                    OP_SUB:  n = n - t;
                    OP_AND:  n = n & t;
                    OP_OR:   n = n | t;
                    default: n = n ^ t;
                endcase
                dstk[top] = n;
            end
            OP_DIVMOD:
            begin
                // Signed truncating divide; a zero divisor leaves the dividend as remainder.
                t = dstk[top];
                sec = second_cell();
                n = dstk[sec];
                if (t == 0)
                begin
                    q = '0;
                    r = n;
                end
                else
                begin
                    an = n[31] ? -n : n;
                    at = t[31] ? -t : t;
                    q = an / at;
                    r = an % at;
                    if (n[31] ^ t[31])
                        q = -q;
                    if (n[31])
                        r = -r;
                end
                dstk[top] = q;
                dstk[sec] = r;
            end
            OP_INC: dstk[top] = dstk[top] + 1;
            OP_DEC: dstk[top] = dstk[top] - 1;
            OP_LT, OP_EQ, OP_GT:
            begin
                t = pop_data();
                top = dsp;
                n = dstk[top];
                if (ir == OP_LT)
                    dstk[top] = ($signed(n) < $signed(t)) ? 1 : 0;
                else if (ir == OP_EQ)
                    dstk[top] = (n == t) ? 1 : 0;
                else
                    dstk[top] = ($signed(t) < $signed(n)) ? 1 : 0;
            end
            OP_ZEQ: dstk[top] = (dstk[top] == 0) ? 1 : 0;
            OP_PLUSST:
            begin
                t = pop_data();
                n = pop_data();
                mem_img[t[ADDR_W-1:0]] = mem_img[t[ADDR_W-1:0]] + n;
            end
            OP_FOR:
            begin
                n = pop_data();
                if (lsp + 3 > STK_DEPTH)
                    st = ST_LOOPOV;
                else
                begin
                    lsp += 3;
                    lsp_m = lsp;
                    lstk[lsp] = '0;
                    lstk[lsp - 1] = n;
                    lstk[lsp - 2] = {20'h0, pc};
                end
            end
            OP_I: push_data(lstk[lsp]);
            OP_NEXT:
            begin
                if (lsp >= 3)
                begin
                    w = lstk[lsp] + 1;
                    lstk[lsp] = w;
                    if ($signed(w) < $signed(lstk[lsp - 1]))
                        pc = lstk[lsp - 2][ADDR_W-1:0];
                    else
                        lsp_m = lsp - 3;
                end
            end
            default:
            begin
                // Unsupported primitives, short literals, then calls.
                if (ir >= OP_UNS_LO && ir <= OP_UNS_HI)
                    st = ST_UNSUP;
                else if (ir[30])
                    push_data({2'b00, ir[29:0]});
                else
                begin
                    if (mem_img[pc] != 0)
                        push_ret({20'h0, pc});
                    pc = ir[ADDR_W-1:0];
                end
            end
        endcase
        pc_m = pc;
        return st;
    endfunction

    // Apply one accepted word to the predicted state and give the expected result.
    function automatic outcome_t predict_outcome(logic [ACT_W-1:0] a, logic [ADDR_W-1:0] adr,
                                                 logic [CELL_W-1:0] d);
        outcome_t o;
        o.rd = '0;
        o.st = ST_RUN;
        case (a)
            ACT_WRITE:
            begin
                mem_img[adr] = d;
                o.st = halted_m ? ST_HALT : ST_RUN;
            end
            ACT_READ:
            begin
                o.rd = mem_img[adr];
                o.st = halted_m ? ST_HALT : ST_RUN;
            end
            ACT_PC:
            begin
                pc_m = adr;
                halted_m = 1'b0;
            end
            default: o.st = halted_m ? ST_HALT : run_instruction();
        endcase
        o.pc = pc_m;
        o.tos = dstk[dsp];
        return o;
    endfunction

    // Offer one word, wait for it to be taken, and queue its expected result.
    task automatic send_word(logic [ACT_W-1:0] a, logic [ADDR_W-1:0] adr, logic [CELL_W-1:0] d,
                             bit typed = 1'b0, outcome_t given = '{default: '0});
        outcome_t o;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= a;
        address <= adr;
        data <= d;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        o = predict_outcome(a, adr, d);
        pending_results.push_back(typed ? given : o);
    endtask

    // Check every result word against the oldest expectation.
    always @(negedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result word with nothing expected", $realtime);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (program_counter !== e.pc)
                    report_mismatch("program_counter", program_counter, e.pc);
                if (top_of_stack !== e.tos)
                    report_mismatch("top_of_stack", top_of_stack, e.tos);
                if (read_word !== e.rd)
                    report_mismatch("read_word", read_word, e.rd);
                if (status !== e.st)
                    report_mismatch("status", status, e.st);
            end
        end
    end

    function automatic logic [CELL_W-1:0] pick_cell();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus.
    initial
    begin
        row_t              rows[$];
        outcome_t          o;
        logic [CELL_W-1:0] prog[$];
        logic [CELL_W-1:0] w;
        logic [ADDR_W-1:0] base;
        int                items, len, kind;

        for (int i = 0; i < STK_ENTRIES; i++)
        begin
            dstk[i] = '0;
            rstk[i] = '0;
            lstk[i] = '0;
            fstk[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Give every memory word a value so that nothing unwritten is ever read.
        for (int i = 0; i < MEM_WORDS; i++)
            send_word(ACT_WRITE, ADDR_W'(i), CELL_W'($urandom_range(0, 63)));
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        // Directed table: extremes, halt, unsupported, zero divide, loop overflow, min / -1.
        rows = '{
            '{ACT_WRITE, 12'hFFF, 32'hFFFF_FFFF, 1, 1, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_READ,  12'hFFF, 32'h0, 1, 1, 12'd0, 32'h0, 32'hFFFF_FFFF, ST_RUN},
            '{ACT_WRITE, 12'd0, 32'(OP_EXIT), 1, 1, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_PC,    12'hFFF, 32'h0, 1, 1, 12'hFFF, 32'h0, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 1, 1, 12'd0, 32'h3FFF_FFFF, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 1, 1, 12'd0, 32'h3FFF_FFFF, 32'h0, ST_HALT},
            '{ACT_EXEC,  12'hFFF, 32'hFFFF_FFFF, 1, 1, 12'd0, 32'h3FFF_FFFF, 32'h0, ST_HALT},
            '{ACT_WRITE, 12'd10, 32'h4000_0007, 1, 1, 12'd0, 32'h3FFF_FFFF, 32'h0, ST_HALT},
            '{ACT_WRITE, 12'd11, 32'h4000_0000, 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd12, 32'(OP_DIVMOD), 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd13, 32'(OP_UNS_LO), 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_PC,    12'd10, 32'h0, 1, 1, 12'd10, 32'h3FFF_FFFF, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 3, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 1, 1, 12'd14, 32'h0, 32'h0, ST_UNSUP},
            '{ACT_WRITE, 12'd20, 32'(OP_FOR), 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd21, 32'(OP_JMP), 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd22, 32'd20, 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_PC,    12'd20, 32'h0, 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 42, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 1, 1, 12'd21, 32'h0, 32'h0, ST_LOOPOV},
            '{ACT_WRITE, 12'd40, 32'(OP_LIT), 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd41, 32'h8000_0000, 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd42, 32'(OP_LIT), 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd43, 32'hFFFF_FFFF, 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_WRITE, 12'd44, 32'(OP_DIVMOD), 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_PC,    12'd40, 32'h0, 1, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 2, 0, 12'd0, 32'h0, 32'h0, ST_RUN},
            '{ACT_EXEC,  12'd0, 32'h0, 1, 1, 12'd45, 32'h8000_0000, 32'h0, ST_RUN}
        };
        foreach (rows[k])
        begin
            o = '{rows[k].e_pc, rows[k].e_tos, rows[k].e_rd, rows[k].e_st};
            repeat (rows[k].reps)
                send_word(rows[k].act, rows[k].adr, rows[k].dat, rows[k].typed, o);
        end

        // Random part: mostly short programs with random content, some noise.
        items = 0;
        while (items < 600)
        begin
            // Change the sender's idling at each third, draining first.
            if (items >= 200 && gap_pct == 15 || items >= 400 && gap_pct == 67)
            begin
                start <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                @(posedge clk);
                gap_pct = (gap_pct == 15) ? 67 : 0;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                base = ADDR_W'($urandom);
                len = $urandom_range(6, 14);
                prog.delete();
                while (prog.size() < len)
                begin
                    kind = $urandom_range(0, 99);
                    if (kind < 60)
                    begin
                        w = $urandom_range(0, 42);
                        prog.push_back(w);
                        if (w == OP_LIT)
                            prog.push_back(pick_cell());
                        else if (w >= OP_JMP && w <= OP_NJMPNZ)
                            prog.push_back(32'(ADDR_W'(base + $urandom_range(0, len))));
                    end
                    else if (kind < 65)
                        prog.push_back($urandom_range(OP_UNS_LO, OP_UNS_HI));
                    else if (kind < 88)
                        prog.push_back({1'($urandom), 1'b1, 30'($urandom)});
                    else
                        prog.push_back({$urandom_range(0, 1) ? 20'h0 : 20'h8_0000,
                                        ADDR_W'(base + $urandom_range(0, len))});
                end
                foreach (prog[k])
                    send_word(ACT_WRITE, ADDR_W'(base + k), prog[k]);
                send_word(ACT_PC, base, $urandom);
                items += prog.size() + 1;
                repeat ($urandom_range(8, 30))
                begin
                    send_word(ACT_EXEC, ADDR_W'($urandom), $urandom);
                    items++;
                end
            end
            else
            begin
                send_word(ACT_W'($urandom_range(0, 3)), ADDR_W'($urandom), $urandom);
                items++;
            end
        end
        start <= 1'b0;

        // Drain, then allow for the slowest instruction.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ===== forth_stack_machine_core_unit.f =====
hw/rtl/fsmc_pkg.sv
hw/rtl/fsmc_ram.sv
hw/rtl/fsmc_stk.sv
hw/rtl/fsmc_div.sv
hw/rtl/fsmc_ctrl.sv
hw/rtl/fsmc_dp.sv
hw/rtl/forth_stack_machine_core_unit.sv
bench/forth_stack_machine_core_unit_tb.sv
